FILE: design/mmac_pkg.sv
package mmac_pkg;

  localparam int CLOCK_BITS = 32;
  localparam int CNT_W      = $clog2(CLOCK_BITS + 1);
  localparam int BEATS_W    = 8;
  localparam int CPB_W      = 10;
  localparam int SPAN_W     = BEATS_W + CPB_W;
  localparam int WORD_W     = 14;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] FUNC_BEAT   = 2'd0;
  localparam logic [1:0] FUNC_PHASE  = 2'd1;
  localparam logic [1:0] FUNC_RECORD = 2'd2;

  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_CHANNEL   = 3'd1;
  localparam logic [2:0] REG_BEATS     = 3'd2;
  localparam logic [2:0] REG_CPB       = 3'd3;
  localparam logic [2:0] REG_NORMAL    = 3'd4;
  localparam logic [2:0] REG_ACCENT    = 3'd5;
  localparam logic [2:0] REG_RECORD    = 3'd6;
  localparam logic [2:0] REG_NOTE_OFF  = 3'd7;

  localparam logic MSG_NOTE_ON  = 1'b0;
  localparam logic MSG_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic                  done;
    logic [CLOCK_BITS-1:0] quo;
    logic [SPAN_W-1:0]     rem;
  } div_res_t;

endpackage

FILE: design/midi_metronome_accent_counter_unit.sv
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_ready   | func, clock_position
// out      | output    | out_valid/out_ready | message_kind, channel, note_number, velocity, last
// cfg      | input     | cfg_write           | cfg_index, cfg_data
// Beat tick and record run S_ON, then S_OFF when note-off is on; set phase runs S_MUL, then two
// passes of one shift-subtract divider, one quotient bit per cycle over CLOCK_BITS bits.
// A four-message output queue lets the next item enter while results still wait.
// rst is synchronous: registers return to their defaults and the beat count to zero.
// in_ready drops while an item is at work or the queue lacks room for two messages.
module midi_metronome_accent_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] clock_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        message_kind,
  output logic [3:0]  channel,
  output logic [6:0]  note_number,
  output logic [6:0]  velocity,
  output logic        last,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_D1S  = 3'd2;
  localparam logic [2:0] S_D1W  = 3'd3;
  localparam logic [2:0] S_D2S  = 3'd4;
  localparam logic [2:0] S_D2W  = 3'd5;
  localparam logic [2:0] S_ON   = 3'd6;
  localparam logic [2:0] S_OFF  = 3'd7;

  logic [2:0]                      state;
  logic                            enabled;
  logic [3:0]                      midi_channel;
  logic [mmac_pkg::BEATS_W-1:0]    beats_per_measure;
  logic [mmac_pkg::CPB_W-1:0]      clocks_per_beat;
  logic [mmac_pkg::WORD_W-1:0]     normal_note_word;
  logic [mmac_pkg::WORD_W-1:0]     accent_note_word;
  logic [mmac_pkg::WORD_W-1:0]     record_note_word;
  logic                            send_note_off;
  logic [mmac_pkg::BEATS_W-1:0]    beats_remaining;
  logic [mmac_pkg::WORD_W-1:0]     cur_word;
  logic [mmac_pkg::CLOCK_BITS-1:0] clk_pos;
  logic [mmac_pkg::SPAN_W-1:0]     span;
  logic [63:0]                     pos64;
  logic                            accept;
  logic                            room2;
  logic                            div_start;
  logic [mmac_pkg::CLOCK_BITS-1:0] div_dividend;
  logic [mmac_pkg::SPAN_W-1:0]     div_divisor;
  mmac_pkg::div_res_t              div_res;
  logic                            push;
  mmac_pkg::msg_t                  push_msg;
  mmac_pkg::msg_t                  out_msg;
  logic [mmac_pkg::BEATS_W-1:0]    phase_v;

  assign in_ready = (state == S_IDLE) && room2;
  assign accept   = in_valid && in_ready;
  assign pos64    = {32'b0, clock_position};
  assign phase_v  = div_res.quo[mmac_pkg::BEATS_W-1:0];

  assign div_start    = (state == S_D1S) || (state == S_D2S);
  assign div_dividend = (state == S_D1S) ? clk_pos
                      : mmac_pkg::CLOCK_BITS'(div_res.rem);
  assign div_divisor  = (state == S_D1S) ? span
                      : {{mmac_pkg::BEATS_W{1'b0}}, clocks_per_beat};

  assign push = (state == S_ON) || (state == S_OFF);

  always_comb begin
    push_msg.channel = midi_channel;
    push_msg.note    = cur_word[6:0];
    if (state == S_OFF) begin
      push_msg.kind = mmac_pkg::MSG_NOTE_OFF;
      push_msg.vel  = 7'd0;
      push_msg.last = 1'b1;
    end else begin
      push_msg.kind = mmac_pkg::MSG_NOTE_ON;
      push_msg.vel  = cur_word[13:7];
      push_msg.last = !send_note_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      enabled           <= 1'b1;
      midi_channel      <= 4'd9;
      beats_per_measure <= 8'd4;
      clocks_per_beat   <= 10'd96;
      normal_note_word  <= 14'd7717;
      accent_note_word  <= 14'd16293;
      record_note_word  <= 14'd16311;
      send_note_off     <= 1'b1;
      beats_remaining   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (func)
              mmac_pkg::FUNC_BEAT: begin
                if (enabled) begin
                  state <= S_ON;
                  if (beats_remaining != '0) begin
                    beats_remaining <= beats_remaining - 1'b1;
                  end else if (beats_per_measure != '0) begin
                    beats_remaining <= beats_per_measure - 1'b1;
                  end
                end
              end
              mmac_pkg::FUNC_PHASE: begin
                if (beats_per_measure != '0 && clocks_per_beat != '0) state <= S_MUL;
              end
              mmac_pkg::FUNC_RECORD: begin
                if (record_note_word[6:0] != '0 && record_note_word[13:7] != '0) begin
                  state <= S_ON;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: state <= S_D1S;
        S_D1S: state <= S_D1W;
        S_D1W: if (div_res.done) state <= S_D2S;
        S_D2S: state <= S_D2W;
        S_D2W: begin
          if (div_res.done) begin
            beats_remaining <= (phase_v == '0) ? '0 : beats_per_measure - phase_v;
            state           <= S_IDLE;
          end
        end
        S_ON: state <= send_note_off ? S_OFF : S_IDLE;
        S_OFF: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cfg_write) begin
        unique case (cfg_index)
          mmac_pkg::REG_ENABLED:  enabled          <= cfg_data[0];
          mmac_pkg::REG_CHANNEL:  midi_channel     <= cfg_data[3:0];
          mmac_pkg::REG_BEATS: begin
            beats_per_measure <= cfg_data[7:0];
            beats_remaining   <= '0;
          end
          mmac_pkg::REG_CPB: begin
            clocks_per_beat <= cfg_data[9:0];
            beats_remaining <= '0;
          end
          mmac_pkg::REG_NORMAL:   normal_note_word <= cfg_data;
          mmac_pkg::REG_ACCENT:   accent_note_word <= cfg_data;
          mmac_pkg::REG_RECORD:   record_note_word <= cfg_data;
          mmac_pkg::REG_NOTE_OFF: send_note_off    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clk_pos <= pos64[mmac_pkg::CLOCK_BITS-1:0];
      if (func == mmac_pkg::FUNC_RECORD) begin
        cur_word <= record_note_word;
      end else if (beats_remaining != '0) begin
        cur_word <= normal_note_word;
      end else begin
        cur_word <= accent_note_word;
      end
    end
    if (state == S_MUL) begin
      span <= {{mmac_pkg::CPB_W{1'b0}}, beats_per_measure}
            * {{mmac_pkg::BEATS_W{1'b0}}, clocks_per_beat};
    end
  end

  mmac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  mmac_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_msg  (push_msg),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_msg   (out_msg)
  );

  assign message_kind = out_msg.kind;
  assign channel      = out_msg.channel;
  assign note_number  = out_msg.note;
  assign velocity     = out_msg.vel;
  assign last         = out_msg.last;

endmodule

FILE: design/mmac_div.sv
module mmac_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mmac_pkg::CLOCK_BITS-1:0] dividend,
  input  logic [mmac_pkg::SPAN_W-1:0]     divisor,
  output mmac_pkg::div_res_t              res
);

  logic [mmac_pkg::SPAN_W-1:0]     rem;
  logic [mmac_pkg::CLOCK_BITS-1:0] quo;
  logic [mmac_pkg::SPAN_W-1:0]     dvs;
  logic [mmac_pkg::CNT_W-1:0]      cnt;
  logic                            done;
  logic [mmac_pkg::SPAN_W:0]       sh;
  logic [mmac_pkg::SPAN_W:0]       diff;
  logic                            ge;

  assign sh   = {rem, quo[mmac_pkg::CLOCK_BITS-1]};
  assign ge   = sh >= {1'b0, dvs};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= mmac_pkg::CNT_W'(mmac_pkg::CLOCK_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == mmac_pkg::CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[mmac_pkg::SPAN_W-1:0] : sh[mmac_pkg::SPAN_W-1:0];
      quo <= {quo[mmac_pkg::CLOCK_BITS-2:0], ge};
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

FILE: design/mmac_out.sv
module mmac_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mmac_pkg::msg_t     push_msg,
  output logic               room2,
  output logic               out_valid,
  input  logic               out_ready,
  output mmac_pkg::msg_t     out_msg
);

  mmac_pkg::msg_t                mem [mmac_pkg::FIFO_DEPTH];
  logic [mmac_pkg::PTR_W-1:0]    wr_ptr;
  logic [mmac_pkg::PTR_W-1:0]    rd_ptr;
  logic [mmac_pkg::FCNT_W-1:0]   count;
  logic                          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign room2     = count <= mmac_pkg::FCNT_W'(mmac_pkg::FIFO_DEPTH - 2);
  assign out_msg   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_msg;
  end

endmodule

FILE: design/mmac_checker.sv
module mmac_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       message_kind,
  input logic [6:0] note_number,
  input logic [6:0] velocity,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_kind == mmac_pkg::MSG_NOTE_OFF) |-> velocity == 7'd0)
    else $error("note-off with nonzero velocity");

  a_off_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_kind == mmac_pkg::MSG_NOTE_OFF) |-> last)
    else $error("note-off not marked last");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_hold_note: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(note_number) && $stable(message_kind)))
    else $error("output item changed while stalled");

endmodule

bind midi_metronome_accent_counter_unit mmac_checker u_mmac_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .message_kind (message_kind),
  .note_number  (note_number),
  .velocity     (velocity),
  .last         (last)
);
